@@ design/iirs_pkg.sv @@
// Package for the summed-area region statistics block.
// Holds sizes, command codes and shared types; no dependencies.
package iirs_pkg;
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int AW        = XW + YW;
  localparam int Depth     = MaxWidth * MaxHeight;
  localparam int NLanes    = 3;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_QUERY = 1'b1} cmd_t;
  typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_idx_t;
  typedef enum logic [1:0] {ST_IDLE, ST_RD1, ST_RD2, ST_MERGE} state_t;

  typedef struct packed {
    logic [23:0] sum;
    logic [31:0] sumsq;
  } lane_res_t;
endpackage

@@ design/integral_image_region_stats.sv @@
// Top level: summed-area tables of RGB and RGB squared with square queries.
// Depends on iirs_pkg, iirs_lane, iirs_merge.
//
//  channel | ports                     | role
//  in_     | in_valid/in_ready + fields| load pixel or query square
//  out_    | out_valid/out_ready + flds| one result per query
//  cfg_    | cfg_we/cfg_index/cfg_data | image width and height
//
// A load reads the left neighbors from the table RAMs in the accept cycle and
// writes in the next. A query makes two dual-port reads of the four corners
// (accept cycle and the next), takes the second pair in ST_RD2, then merges
// into the output register in ST_MERGE; one item at a time.
// Reset clears the load position and control state and sets width and height to the maximum; tables stay undefined.
// The output register holds a result until taken; a query whose result finds
// it full waits in the merge state and stalls all input, loads included.
module integral_image_region_stats import iirs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_corner_x,
  input  logic [7:0]  in_corner_y,
  input  logic [3:0]  in_side_log2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_sum_red,
  output logic [23:0] out_sum_green,
  output logic [23:0] out_sum_blue,
  output logic [31:0] out_sumsq_red,
  output logic [31:0] out_sumsq_green,
  output logic [31:0] out_sumsq_blue,
  output logic [7:0]  out_avg_red,
  output logic [7:0]  out_avg_green,
  output logic [7:0]  out_avg_blue,
  output logic [49:0] out_deviation_times_area,
  output logic        out_out_of_range
);
  state_t state_r, state_nxt;
  logic [8:0] width_r, height_r, ew, eh;
  logic [8:0] col_r, row_r, col_nxt, row_nxt;
  logic [XW-1:0] lx_r;
  logic [YW-1:0] ly_r;
  logic          lrow0_r, load_r;
  logic [7:0]  pix_r [NLanes];
  logic [XW:0] xa_r, xb_r;
  logic [YW:0] ya_r;
  logic [3:0]  s_r;
  logic        oor_r;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic ena, enb, first, capture, plus_a, plus_b, ld_we, accept;
  logic out_free, merge_go;
  logic [8:0] side9, endx, endy;
  lane_res_t lr [NLanes];
  logic [7:0] avg [NLanes];
  logic [49:0] dev;

  // Clamp the frame size registers to 1..max.
  always_comb begin
    ew = (width_r == 9'd0) ? 9'd1 : (width_r > 9'(MaxWidth) ? 9'(MaxWidth) : width_r);
    eh = (height_r == 9'd0) ? 9'd1 : (height_r > 9'(MaxHeight) ? 9'(MaxHeight) : height_r);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign merge_go = (state_r == ST_MERGE) && out_free;
  assign side9    = 9'd1 << in_side_log2;
  assign endx     = {1'b0, in_corner_x} + side9;
  assign endy     = {1'b0, in_corner_y} + side9;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_RD1;
      ST_RD1:   state_nxt = load_r ? ST_IDLE : ST_RD2;
      ST_RD2:   state_nxt = ST_MERGE;
      ST_MERGE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Load position: restart when outside the current frame size.
  logic [8:0] cx, cy;
  always_comb begin
    cx = (col_r >= ew || row_r >= eh) ? 9'd0 : col_r;
    cy = (col_r >= ew || row_r >= eh) ? 9'd0 : row_r;
    row_nxt = cy + 9'd1;
    col_nxt = cx;
    if (row_nxt >= eh) begin
      row_nxt = 9'd0;
      col_nxt = (cx + 9'd1 >= ew) ? 9'd0 : cx + 9'd1;
    end
  end

  // Read addresses and lane controls.
  always_comb begin
    ena = 1'b0; enb = 1'b0; raddr_a = '0; raddr_b = '0;
    first = 1'b0; capture = 1'b0; plus_a = 1'b1; plus_b = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_LOAD) begin
          raddr_a = {XW'(cx - 9'd1), YW'(cy)};
          raddr_b = {XW'(cx - 9'd1), YW'(cy - 9'd1)};
        end else begin
          raddr_a = {XW'(endx - 9'd1), YW'(endy - 9'd1)};
          raddr_b = {XW'({1'b0, in_corner_x} - 9'd1), YW'(endy - 9'd1)};
        end
      end
      ST_RD1: begin
        raddr_a = {XW'(xb_r), YW'(ya_r)};
        raddr_b = {XW'(xa_r), YW'(ya_r)};
        if (load_r) begin
          ena = (lx_r != '0);
          enb = (lx_r != '0) && !lrow0_r;
        end else begin
          ena = 1'b1; enb = (xa_r[XW] == 1'b0);
          first = 1'b1; capture = 1'b1; plus_b = 1'b0;
        end
      end
      ST_RD2: begin
        ena = (ya_r[YW] == 1'b0);
        enb = (ya_r[YW] == 1'b0) && (xa_r[XW] == 1'b0);
        capture = 1'b1; plus_a = 1'b0;
      end
      default: ;
    endcase
  end

  assign ld_we = (state_r == ST_RD1) && load_r;
  assign waddr = {lx_r, ly_r};

  iirs_lane u_lane_r (.clk, .rst_n, .ld_we, .row0(lrow0_r), .pix(pix_r[0]), .waddr,
    .raddr_a, .raddr_b, .ena, .enb, .first, .capture, .plus_a, .plus_b, .res(lr[0]));
  iirs_lane u_lane_g (.clk, .rst_n, .ld_we, .row0(lrow0_r), .pix(pix_r[1]), .waddr,
    .raddr_a, .raddr_b, .ena, .enb, .first, .capture, .plus_a, .plus_b, .res(lr[1]));
  iirs_lane u_lane_b (.clk, .rst_n, .ld_we, .row0(lrow0_r), .pix(pix_r[2]), .waddr,
    .raddr_a, .raddr_b, .ena, .enb, .first, .capture, .plus_a, .plus_b, .res(lr[2]));

  iirs_merge u_merge (.lr, .side_log2(s_r), .avg, .dev);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      width_r   <= 9'(MaxWidth);
      height_r  <= 9'(MaxHeight);
      col_r     <= '0;
      row_r     <= '0;
      out_valid <= 1'b0;
      load_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
      if (accept) load_r <= (in_command == CMD_LOAD);
      if (accept && in_command == CMD_LOAD) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      // Raise the result when the merge lands in a free output register.
      if (merge_go) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lx_r     <= XW'(cx);
      ly_r     <= YW'(cy);
      lrow0_r  <= (cy == 9'd0);
      pix_r[0] <= in_red;
      pix_r[1] <= in_green;
      pix_r[2] <= in_blue;
      xa_r     <= (XW+1)'({1'b0, in_corner_x} - 9'd1);
      ya_r     <= (YW+1)'({1'b0, in_corner_y} - 9'd1);
      xb_r     <= (XW+1)'(endx - 9'd1);
      s_r      <= in_side_log2;
      oor_r    <= (endx > ew) || (endy > eh) || (in_side_log2 > 4'd8);
    end
    if (merge_go) begin
      out_out_of_range         <= oor_r;
      out_sum_red              <= oor_r ? '0 : lr[0].sum;
      out_sum_green            <= oor_r ? '0 : lr[1].sum;
      out_sum_blue             <= oor_r ? '0 : lr[2].sum;
      out_sumsq_red            <= oor_r ? '0 : lr[0].sumsq;
      out_sumsq_green          <= oor_r ? '0 : lr[1].sumsq;
      out_sumsq_blue           <= oor_r ? '0 : lr[2].sumsq;
      out_avg_red              <= oor_r ? '0 : avg[0];
      out_avg_green            <= oor_r ? '0 : avg[1];
      out_avg_blue             <= oor_r ? '0 : avg[2];
      out_deviation_times_area <= oor_r ? '0 : dev;
    end
  end
endmodule

@@ design/iirs_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module iirs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

@@ design/iirs_lane.sv @@
// One color lane: sum and square-sum tables, load update and corner combine.
// Depends on iirs_pkg and iirs_ram.
module iirs_lane import iirs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld_we,
  input  logic          row0,
  input  logic [7:0]    pix,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  input  logic          ena,
  input  logic          enb,
  input  logic          first,
  input  logic          capture,
  input  logic          plus_a,
  input  logic          plus_b,
  output lane_res_t     res
);
  logic [23:0] s_a, s_b, prev_s_r, acc_s_r, acc_s_nxt, ws, xa_s, xb_s;
  logic [31:0] q_a, q_b, prev_q_r, acc_q_r, acc_q_nxt, wq, xa_q, xb_q;
  logic [15:0] sq;

  iirs_ram #(.Width(24), .Depth(Depth)) u_s (
    .clk, .we(ld_we), .waddr, .wdata(ws), .raddr_a, .raddr_b,
    .rdata_a(s_a), .rdata_b(s_b));
  iirs_ram #(.Width(32), .Depth(Depth)) u_q (
    .clk, .we(ld_we), .waddr, .wdata(wq), .raddr_a, .raddr_b,
    .rdata_a(q_a), .rdata_b(q_b));

  assign sq   = {8'd0, pix} * {8'd0, pix};
  assign xa_s = ena ? s_a : 24'd0;
  assign xb_s = enb ? s_b : 24'd0;
  assign xa_q = ena ? q_a : 32'd0;
  assign xb_q = enb ? q_b : 32'd0;

  // Load: port a holds (x-1,y), port b holds (x-1,y-1), read in the cycle before.
  always_comb begin
    ws = {16'd0, pix} + xa_s + (row0 ? 24'd0 : prev_s_r) - xb_s;
    wq = {16'd0, sq} + xa_q + (row0 ? 32'd0 : prev_q_r) - xb_q;
  end

  always_comb begin
    acc_s_nxt = first ? 24'd0 : acc_s_r;
    acc_q_nxt = first ? 32'd0 : acc_q_r;
    acc_s_nxt = plus_a ? acc_s_nxt + xa_s : acc_s_nxt - xa_s;
    acc_q_nxt = plus_a ? acc_q_nxt + xa_q : acc_q_nxt - xa_q;
    acc_s_nxt = plus_b ? acc_s_nxt + xb_s : acc_s_nxt - xb_s;
    acc_q_nxt = plus_b ? acc_q_nxt + xb_q : acc_q_nxt - xb_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_s_r <= '0;
      prev_q_r <= '0;
    end else if (ld_we) begin
      prev_s_r <= ws;
      prev_q_r <= wq;
    end
    if (capture) begin
      acc_s_r <= acc_s_nxt;
      acc_q_r <= acc_q_nxt;
    end
  end

  assign res.sum   = acc_s_r;
  assign res.sumsq = acc_q_r;
endmodule

@@ design/iirs_merge.sv @@
// Merge stage: averages and summed deviation across the three lanes.
// Depends on iirs_pkg.
module iirs_merge import iirs_pkg::*; (
  input  lane_res_t       lr [NLanes],
  input  logic [3:0]      side_log2,
  output logic [7:0]      avg [NLanes],
  output logic [49:0]     dev
);
  logic [49:0] term [NLanes];
  logic [47:0] sq   [NLanes];
  logic [4:0]  sh;

  assign sh = {side_log2, 1'b0};
  always_comb begin
    for (int i = 0; i < NLanes; i++) begin
      avg[i]  = 8'(lr[i].sum >> sh);
      sq[i]   = lr[i].sum * lr[i].sum;
      term[i] = (50'(lr[i].sumsq) << sh) - 50'(sq[i]);
    end
    dev = term[0] + term[1] + term[2];
  end
endmodule

@@ tb/sv/integral_image_region_stats_tb.sv @@
// Self-checking testbench for integral_image_region_stats: summed-area table loads and
// square-region queries, checked item by item against an in-bench predictor.
// Depends on iirs_pkg and the DUT only.
module integral_image_region_stats_tb;
  import iirs_pkg::*;

  localparam int   NTAB       = 6;
  localparam int   DRAIN_CYC  = 10;

  typedef struct {
    logic [23:0] sum_r, sum_g, sum_b;
    logic [31:0] sq_r, sq_g, sq_b;
    logic [7:0]  avg_r, avg_g, avg_b;
    logic [49:0] dev;
    logic        oor;
  } region_stats_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] r, g, b, x, y;
    logic [3:0] s;
    bit         typed_oor;   // expected result is the out-of-range pattern, typed in
  } pixel_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = 1'b0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic [7:0]  in_corner_x = '0, in_corner_y = '0;
  logic [3:0]  in_side_log2 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_sum_red, out_sum_green, out_sum_blue;
  logic [31:0] out_sumsq_red, out_sumsq_green, out_sumsq_blue;
  logic [7:0]  out_avg_red, out_avg_green, out_avg_blue;
  logic [49:0] out_deviation_times_area;
  logic        out_out_of_range;

  integral_image_region_stats DUT (.*);

  always #1 clk = ~clk;

  // ---------------- predictor state ----------------
  int unsigned sat_tab [NTAB][MaxWidth*MaxHeight];
  int unsigned sat_prev [NTAB];
  int unsigned width_reg = 256, height_reg = 256;
  int unsigned load_col = 0, load_row = 0;

  region_stats_t pending_stats[$];
  int  fail_count = 0;
  bit  quiet = 1'b0;      // no idling on either side
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off

  function automatic int unsigned eff_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned tab_mask(int t);
    return (t < 3) ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
  endfunction

  // Off-image corners (coordinate -1) read as zero.
  function automatic int unsigned sat_at(int t, int x, int y);
    if (x < 0 || y < 0) return 0;
    return sat_tab[t][x*MaxHeight + y];
  endfunction

  function automatic void sat_load(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, p, v;
    int unsigned pix [3];
    int x, y;
    w = eff_size(width_reg, MaxWidth);
    h = eff_size(height_reg, MaxHeight);
    // position outside a shrunk frame restarts at the origin
    if (load_col >= w || load_row >= h) begin
      load_col = 0;
      load_row = 0;
    end
    x = load_col;
    y = load_row;
    if (y == 0) sat_prev = '{default: 0};
    pix = '{32'(r), 32'(g), 32'(b)};
    for (int t = 0; t < NTAB; t++) begin
      p = (t < 3) ? pix[t] : pix[t-3] * pix[t-3];
      v = (p + sat_at(t, x-1, y) + sat_prev[t] - sat_at(t, x-1, y-1)) & tab_mask(t);
      sat_tab[t][x*MaxHeight + y] = v;
      sat_prev[t] = v;
    end
    load_row = y + 1;
    if (load_row >= h) begin
      load_row = 0;
      load_col = x + 1;
      if (load_col >= w) load_col = 0;
    end
  endfunction

  function automatic region_stats_t oor_stats();
    region_stats_t rs;
    rs = '{default: '0};
    rs.oor = 1'b1;
    return rs;
  endfunction

  function automatic region_stats_t region_query(logic [7:0] x0, logic [7:0] y0,
                                                 logic [3:0] s);
    region_stats_t rs;
    int unsigned side;
    int unsigned sums [NTAB];
    longint unsigned dev, sm, sq;
    int xa, ya, xb, yb;
    logic [7:0] avg [3];
    side = 1 << s;
    if (x0 + side > eff_size(width_reg, MaxWidth) ||
        y0 + side > eff_size(height_reg, MaxHeight)) return oor_stats();
    xa = int'(x0) - 1;
    ya = int'(y0) - 1;
    xb = int'(x0) + int'(side) - 1;
    yb = int'(y0) + int'(side) - 1;
    for (int t = 0; t < NTAB; t++)
      sums[t] = (sat_at(t, xb, yb) - sat_at(t, xa, yb) - sat_at(t, xb, ya)
                 + sat_at(t, xa, ya)) & tab_mask(t);
    dev = 0;
    for (int c = 0; c < 3; c++) begin
      sm = sums[c];
      sq = sums[c+3];
      avg[c] = 8'((sm >> (2*s)) & 64'hFF);
      dev += (sq << (2*s)) - sm*sm;
    end
    rs.sum_r = 24'(sums[0]); rs.sum_g = 24'(sums[1]); rs.sum_b = 24'(sums[2]);
    rs.sq_r  = sums[3]; rs.sq_g  = sums[4]; rs.sq_b  = sums[5];
    rs.avg_r = avg[0];  rs.avg_g = avg[1];  rs.avg_b = avg[2];
    rs.dev   = dev[49:0];
    rs.oor   = 1'b0;
    return rs;
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    region_stats_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        $error("result with no query outstanding");
        fail_count++;
      end else begin
        e = pending_stats.pop_front();
        check_field("sum_red", e.sum_r, out_sum_red);
        check_field("sum_green", e.sum_g, out_sum_green);
        check_field("sum_blue", e.sum_b, out_sum_blue);
        check_field("sumsq_red", e.sq_r, out_sumsq_red);
        check_field("sumsq_green", e.sq_g, out_sumsq_green);
        check_field("sumsq_blue", e.sq_b, out_sumsq_blue);
        check_field("avg_red", e.avg_r, out_avg_red);
        check_field("avg_green", e.avg_g, out_avg_green);
        check_field("avg_blue", e.avg_b, out_avg_blue);
        check_field("deviation_times_area", e.dev, out_deviation_times_area);
        check_field("out_of_range", e.oor, out_out_of_range);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and drops in_ready while the sender keeps offering.
  always @(posedge clk) begin
    static int stall_left = 0;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 299;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------- stimulus ----------------
  // Drive one item and hold it until accepted; predict at acceptance.
  task automatic send_item(pixel_cmd_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= it.cmd;
    in_red       <= it.r;
    in_green     <= it.g;
    in_blue      <= it.b;
    in_corner_x  <= it.x;
    in_corner_y  <= it.y;
    in_side_log2 <= it.s;
    do @(posedge clk); while (!in_ready);
    if (it.cmd == CMD_LOAD) sat_load(it.r, it.g, it.b);
    else if (it.typed_oor) pending_stats.insert(pending_stats.size(), oor_stats());
    else pending_stats.insert(pending_stats.size(), region_query(it.x, it.y, it.s));
  endtask

  // Pause the sender until every result is back, then cover the load latency.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_stats.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) width_reg = 32'(val);
    else height_reg = 32'(val);
  endtask

  function automatic logic [7:0] rand_chan();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_cmd_t rand_load();
    pixel_cmd_t it;
    it.cmd = CMD_LOAD;
    it.r = rand_chan(); it.g = rand_chan(); it.b = rand_chan();
    it.x = 8'($urandom); it.y = 8'($urandom); it.s = 4'($urandom);  // ignored fields
    it.typed_oor = 1'b0;
    return it;
  endfunction

  // Mostly squares inside the frame; the rest uses the full field ranges.
  function automatic pixel_cmd_t rand_query();
    pixel_cmd_t it;
    int unsigned w, h, maxs, side;
    w = eff_size(width_reg, MaxWidth);
    h = eff_size(height_reg, MaxHeight);
    it.cmd = CMD_QUERY;
    it.r = 8'($urandom); it.g = 8'($urandom); it.b = 8'($urandom);
    it.typed_oor = 1'b0;
    if ($urandom_range(0, 4) != 0) begin
      maxs = 0;
      while ((2 << maxs) <= w && (2 << maxs) <= h) maxs++;
      it.s = 4'($urandom_range(0, maxs));
      side = 1 << it.s;
      it.x = 8'($urandom_range(0, w - side));
      it.y = 8'($urandom_range(0, h - side));
    end else begin
      it.x = 8'($urandom); it.y = 8'($urandom); it.s = 4'($urandom);
    end
    return it;
  endfunction

  // Directed rows. The reset-size rows can only be out-of-range queries, since
  // the 256x256 tables are never filled. The rest runs on a 2x2 frame.
  pixel_cmd_t reset_rows [] = '{
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 4'd1,  1'b1},
    '{CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 4'd8,  1'b1},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd15, 1'b1}
  };
  pixel_cmd_t tiny_rows [] = '{
    '{CMD_LOAD,  8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_LOAD,  8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 4'hF,  1'b0},
    '{CMD_LOAD,  8'h00, 8'hFF, 8'h80, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_LOAD,  8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 4'd0,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 4'd0,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 4'd1,  1'b1},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd2,  1'b1},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 4'd0,  1'b1},
    // frame wrap: this load overwrites the origin
    '{CMD_LOAD,  8'h80, 8'h40, 8'h01, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd15, 1'b1},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 4'd0,  1'b1},
    '{CMD_LOAD,  8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_LOAD,  8'hFE, 8'hFD, 8'hFC, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_LOAD,  8'h7F, 8'h80, 8'hFF, 8'h00, 8'h00, 4'd0,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1,  1'b0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 4'd0,  1'b0}
  };

  // Register settings per phase, including 0 and above-maximum values that clamp.
  typedef struct { logic [8:0] w, h; int mix; } phase_t;
  phase_t phases [] = '{
    '{9'd0,   9'd0,   20}, '{9'd511, 9'd1,   40}, '{9'd1,   9'd300, 40},
    '{9'd8,   9'd8,  120}, '{9'd16,  9'd4,   90}, '{9'd5,   9'd3,   60},
    '{9'd3,   9'd7,   60}
  };

  initial begin
    int unsigned nw, nh, guard;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (reset_rows[i]) send_item(reset_rows[i]);
    drain();
    write_reg(REG_WIDTH, 9'd2);
    write_reg(REG_HEIGHT, 9'd2);
    foreach (tiny_rows[i]) send_item(tiny_rows[i]);

    foreach (phases[p]) begin
      nw = eff_size(32'(phases[p].w), MaxWidth);
      nh = eff_size(32'(phases[p].h), MaxHeight);
      // Finish the current frame unless the position already falls outside the
      // next size; either way the next frame starts at the origin.
      while (!((load_col == 0 && load_row == 0) || load_col >= nw || load_row >= nh))
        send_item(rand_load());
      drain();
      write_reg(REG_WIDTH, phases[p].w);
      write_reg(REG_HEIGHT, phases[p].h);
      if (p == phases.size() - 1) quiet = 1'b1;
      repeat (nw * nh) send_item(rand_load());
      if (p == 3) hold_req = 1'b1;
      repeat (phases[p].mix) begin
        if ($urandom_range(0, 99) < 55) send_item(rand_query());
        else send_item(rand_load());
      end
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending_stats.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0 && pending_stats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ integral_image_region_stats.f @@
design/iirs_pkg.sv
design/iirs_ram.sv
design/iirs_lane.sv
design/iirs_merge.sv
design/integral_image_region_stats.sv
tb/sv/integral_image_region_stats_tb.sv
